// ===== hdl/sacl_pkg.sv =====
// ---------------------------------------------------------------------------
// sacl_pkg
// Shared constants, types and helpers for the LRU cache tag directory.
// ---------------------------------------------------------------------------
package sacl_pkg;

    // Geometry
    localparam int WAYS    = 2;
    localparam int SETS    = 2;
    localparam int ENTRIES = WAYS * SETS;

    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 32;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // tag = address / SETS fits in ADDR_W - floor(log2(SETS)) bits
    localparam int TAG_W   = ADDR_W + 1 - $clog2(SETS + 1);

    localparam int OUT_W   = 8;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CMP   = 4'b0100,
        S_WRITE = 4'b1000
    } state_t;

    // Write request into the directory store
    typedef struct packed {
        logic               we;
        logic               tag_we;
        logic [ENT_W-1:0]   addr;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } wr_req_t;

    // Result of the shared compare unit
    typedef struct packed {
        logic tag_eq;
        logic stamp_lt;
    } cmp_res_t;

    // Flat entry index: set * WAYS + way
    function automatic logic [ENT_W-1:0] entry_index(input logic [SET_W-1:0] set_idx,
                                                     input logic [WAY_W-1:0] way_idx);
        int idx;
        idx = int'(set_idx) * WAYS + int'(way_idx);
        return ENT_W'(idx);
    endfunction

endpackage

// ===== hdl/sacl_cmp.sv =====
// ---------------------------------------------------------------------------
// sacl_cmp
// Shared compare unit: tag equality and stamp ordering for one way.
// ---------------------------------------------------------------------------
module sacl_cmp
    import sacl_pkg::*;
(
    input  logic [TAG_W-1:0]   rd_tag,
    input  logic [TAG_W-1:0]   req_tag,
    input  logic [STAMP_W-1:0] rd_stamp,
    input  logic [STAMP_W-1:0] best_stamp,
    output cmp_res_t           res
);

    // One equality and one unsigned less-than, reused for every way
    always_comb
    begin
        res.tag_eq   = (rd_tag == req_tag);
        res.stamp_lt = (rd_stamp < best_stamp);
    end

endmodule

// ===== hdl/sacl_store.sv =====
// ---------------------------------------------------------------------------
// sacl_store
// Directory storage: tag and stamp memories plus per-entry valid flops.
// ---------------------------------------------------------------------------
module sacl_store
    import sacl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ENT_W-1:0]   rd_addr,
    output logic [TAG_W-1:0]   rd_tag,
    output logic [STAMP_W-1:0] rd_stamp,
    output logic               rd_valid,
    input  wr_req_t            wr
);

    logic [TAG_W-1:0]   tag_mem   [ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_valid_reg;

    // Memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            stamp_mem[wr.addr] <= wr.stamp;
            if (wr.tag_we)
            begin
                tag_mem[wr.addr] <= wr.tag;
            end
        end
        rd_tag   <= tag_mem[rd_addr];
        rd_stamp <= stamp_mem[rd_addr];
    end

    // Valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;

endmodule

// ===== hdl/set_assoc_lru_cache_tags.sv =====
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag directory of a set-associative cache with LRU replacement.
// ---------------------------------------------------------------------------
//  channel  | dir | fields (tdata, low bit first)
//  ---------+-----+------------------------------------------------------
//  s_axis   | in  | address[31:0]
//  m_axis   | out | hit, way_used, filled_empty, evicted, 4'b0 padding
//
//  The ways of the set are scanned one at a time (the scan stops at a hit
//  and covers at most WAYS ways): each way is read from the directory
//  memory in S_READ and then checked by one shared compare unit in S_CMP.
//  s_axis_tready is high only while the sequencer is idle; a result waits in
//  the output register while the next request is taken.
//  Reset clears valid bits, access counter and the output valid flag at once.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_tags
    import sacl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [ADDR_W-1:0] s_axis_tdata,   // [31:0] address
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // [0] hit, [1] way_used,
                                              // [2] filled_empty, [3] evicted
);

    state_t             state_reg, state_next;
    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [STAMP_W-1:0] count_reg;
    logic               hit_reg;
    logic [WAY_W-1:0]   hit_way_reg;
    logic               inv_found_reg;
    logic [WAY_W-1:0]   inv_way_reg;
    logic               have_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [WAY_W-1:0]   best_way_reg;
    logic               out_valid_reg;
    logic [3:0]         out_flags_reg;

    logic [TAG_W-1:0]   rd_tag;
    logic [STAMP_W-1:0] rd_stamp;
    logic               rd_valid;
    cmp_res_t           cmp;
    wr_req_t            wr;
    logic               in_fire;
    logic               out_free;
    logic               last_way;
    logic               hit_now;
    logic [WAY_W-1:0]   sel_way;

    // Storage and shared compare unit
    sacl_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (entry_index(set_reg, way_reg)),
        .rd_tag   (rd_tag),
        .rd_stamp (rd_stamp),
        .rd_valid (rd_valid),
        .wr       (wr)
    );

    sacl_cmp u_cmp (
        .rd_tag     (rd_tag),
        .req_tag    (tag_reg),
        .rd_stamp   (rd_stamp),
        .best_stamp (best_stamp_reg),
        .res        (cmp)
    );

    // Handshake helpers
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign last_way      = (way_reg == WAY_W'(WAYS - 1));
    assign hit_now       = rd_valid && cmp.tag_eq;

    // Way chosen for the update: hit way, first empty way, or oldest way
    always_comb
    begin
        if (hit_reg)
        begin
            sel_way = hit_way_reg;
        end
        else if (inv_found_reg)
        begin
            sel_way = inv_way_reg;
        end
        else
        begin
            sel_way = best_way_reg;
        end
    end

    // Directory update request
    always_comb
    begin
        wr.we     = (state_reg == S_WRITE) && out_free;
        wr.tag_we = !hit_reg;
        wr.addr   = entry_index(set_reg, sel_way);
        wr.tag    = tag_reg;
        wr.stamp  = count_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit_now || last_way)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr.we)
            begin
                count_reg <= count_reg + STAMP_W'(1);
            end
            if (wr.we)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request registers and scan tracking
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            set_reg       <= SET_W'(s_axis_tdata % SETS);
            tag_reg       <= TAG_W'(s_axis_tdata / SETS);
            way_reg       <= '0;
            hit_reg       <= 1'b0;
            inv_found_reg <= 1'b0;
            have_reg      <= 1'b0;
        end
        else if (state_reg == S_CMP)
        begin
            if (hit_now)
            begin
                hit_reg     <= 1'b1;
                hit_way_reg <= way_reg;
            end
            else
            begin
                if (!rd_valid && !inv_found_reg)
                begin
                    inv_found_reg <= 1'b1;
                    inv_way_reg   <= way_reg;
                end
                if (!have_reg || cmp.stamp_lt)
                begin
                    have_reg       <= 1'b1;
                    best_stamp_reg <= rd_stamp;
                    best_way_reg   <= way_reg;
                end
                if (!last_way)
                begin
                    way_reg <= way_reg + WAY_W'(1);
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            out_flags_reg <= {!hit_reg && !inv_found_reg,
                              !hit_reg && inv_found_reg,
                              sel_way[0],
                              hit_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - 4){1'b0}}, out_flags_reg};

`ifndef SYNTHESIS
    // Exactly one of hit, fill and evict per result
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot({m_axis_tdata[0], m_axis_tdata[2], m_axis_tdata[3]}))
        else $error("result carries not exactly one outcome");

    // A directory update always produces a result in the next cycle
    a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |=> m_axis_tvalid)
        else $error("directory update without a result");

    // Access counter advances by one per completed request
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |=> (count_reg == $past(count_reg) + STAMP_W'(1)))
        else $error("access counter did not advance by one");

    // An accepted request starts the way scan
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_READ) && (way_reg == '0))
        else $error("request did not start at the first way");
`endif

endmodule
